// ----- sv/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned OPCODE_W   = 4;
	localparam int unsigned WLEN_W     = 16;
	localparam int unsigned LEN_W      = 64;
	localparam int unsigned KEY_W      = 32;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned OUT_DATA_W = 80;

	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_OPCODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_LENGTH = 1'd1;

	localparam logic [OPCODE_W-1:0] WANTED_OPCODE_RST = 4'h2;
	localparam logic [WLEN_W-1:0]   WANTED_LENGTH_RST = 16'd784;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0]   payload_byte;
		logic                selected;
		logic [LEN_W-1:0]    payload_length;
		logic                masked;
		logic [OPCODE_W-1:0] opcode;
		logic                fin;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/websocket_frame_deframer_top.sv -----
// WebSocket (RFC 6455) client-to-server deframer. One raw stream byte is taken per
// word on the slave side, one byte in every clock cycle while the master side keeps
// up; each byte is decoded combinationally into the next frame state and, where it
// completes a header or carries payload, into one result word held in an output
// register, so a stalled master side holds only that register. Header bytes
// before the last give no word; the header's last byte gives a summary word
// (tuser low) and each payload byte an unmasked byte word (tuser high), with tlast
// on the frame's final word. Fragmentation is not handled, reserved bits are
// ignored and the 64-bit length is used as received.
`default_nettype none

module websocket_frame_deframer_top
	import wsd_pkg::*;
(
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [CFG_IDX_W-1:0]        cfg_index,
	input  wire  [CFG_DATA_W-1:0]       cfg_data,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [BYTE_W-1:0]           s_tdata,    // data_byte
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [OUT_DATA_W-1:0]       m_tdata,    // fin, opcode, masked, payload_length, selected, payload_byte, pad
	output logic                        m_tuser,    // kind
	output logic                        m_tlast
);

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXT     = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [OPCODE_W-1:0] wanted_opcode_q;
	logic [WLEN_W-1:0]   wanted_length_q;

	logic [2:0]          phase_q, phase_d;
	logic [3:0]          ext_count_q, ext_count_d;
	logic [LEN_W-1:0]    frame_length_q, frame_length_d;
	logic [LEN_W-1:0]    remaining_q, remaining_d;
	logic [1:0]          key_idx_q, key_idx_d;
	logic [KEY_W-1:0]    mask_key_q, mask_key_d;
	logic [OPCODE_W-1:0] frame_opcode_q, frame_opcode_d;
	logic                frame_fin_q, frame_fin_d;
	logic                frame_masked_q, frame_masked_d;

	logic                res_valid, res_kind, res_last;
	logic [BYTE_W-1:0]   res_byte;
	logic                hdr_done;
	logic [BYTE_W-1:0]   key_byte;
	logic                accept;
	result_t             res;

	logic                m_tvalid_q;
	result_t             out_s1;
	logic                out_kind_s1, out_last_s1;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_opcode_q <= WANTED_OPCODE_RST;
			wanted_length_q <= WANTED_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WANTED_OPCODE: wanted_opcode_q <= cfg_data[OPCODE_W-1:0];
				CFG_WANTED_LENGTH: wanted_length_q <= cfg_data[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (key_idx_q)
			2'd0: key_byte = mask_key_q[31:24];
			2'd1: key_byte = mask_key_q[23:16];
			2'd2: key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d        = phase_q;
		ext_count_d    = ext_count_q;
		frame_length_d = frame_length_q;
		remaining_d    = remaining_q;
		key_idx_d      = key_idx_q;
		mask_key_d     = mask_key_q;
		frame_opcode_d = frame_opcode_q;
		frame_fin_d    = frame_fin_q;
		frame_masked_d = frame_masked_q;
		res_valid      = 1'b0;
		res_kind       = KIND_HEADER;
		res_last       = 1'b0;
		res_byte       = '0;
		hdr_done       = 1'b0;

		unique case (phase_q)
			PH_HDR1: begin
				frame_masked_d = s_tdata[7];
				if (s_tdata[6:0] == LEN7_EXT16) begin
					frame_length_d = '0;
					phase_d        = PH_EXT;
					ext_count_d    = 4'd2;
				end else if (s_tdata[6:0] == LEN7_EXT64) begin
					frame_length_d = '0;
					phase_d        = PH_EXT;
					ext_count_d    = 4'd8;
				end else begin
					frame_length_d = {{(LEN_W-7){1'b0}}, s_tdata[6:0]};
					hdr_done       = !s_tdata[7];
					if (s_tdata[7]) begin
						phase_d     = PH_MASK;
						ext_count_d = 4'd4;
					end
				end
			end
			PH_EXT: begin
				frame_length_d = {frame_length_q[LEN_W-BYTE_W-1:0], s_tdata};
				ext_count_d    = ext_count_q - 4'd1;
				if (ext_count_q == 4'd1) begin
					hdr_done = !frame_masked_q;
					if (frame_masked_q) begin
						phase_d     = PH_MASK;
						ext_count_d = 4'd4;
					end
				end
			end
			PH_MASK: begin
				mask_key_d  = {mask_key_q[KEY_W-BYTE_W-1:0], s_tdata};
				ext_count_d = ext_count_q - 4'd1;
				hdr_done    = (ext_count_q == 4'd1);
			end
			PH_PAYLOAD: begin
				res_valid   = 1'b1;
				res_kind    = KIND_PAYLOAD;
				res_byte    = frame_masked_q ? (s_tdata ^ key_byte) : s_tdata;
				res_last    = (remaining_q == {{(LEN_W-1){1'b0}}, 1'b1});
				remaining_d = remaining_q - {{(LEN_W-1){1'b0}}, 1'b1};
				key_idx_d   = key_idx_q + 2'd1;
				if (res_last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				frame_fin_d    = s_tdata[7];
				frame_opcode_d = s_tdata[3:0];
				phase_d        = PH_HDR1;
			end
		endcase

		if (hdr_done) begin
			res_valid   = 1'b1;
			key_idx_d   = 2'd0;
			remaining_d = frame_length_d;
			if (frame_length_d == '0) begin
				res_last = 1'b1;
				phase_d  = PH_HDR0;
			end else begin
				phase_d  = PH_PAYLOAD;
			end
		end

		res.fin            = frame_fin_d;
		res.opcode         = frame_opcode_d;
		res.masked         = frame_masked_d;
		res.payload_length = frame_length_d;
		res.selected       = (frame_opcode_d == wanted_opcode_q) &&
			(frame_length_d == {{(LEN_W-WLEN_W){1'b0}}, wanted_length_q});
		res.payload_byte   = res_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR0;
			ext_count_q    <= '0;
			frame_length_q <= '0;
			remaining_q    <= '0;
			key_idx_q      <= '0;
			mask_key_q     <= '0;
			frame_opcode_q <= '0;
			frame_fin_q    <= 1'b0;
			frame_masked_q <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			ext_count_q    <= ext_count_d;
			frame_length_q <= frame_length_d;
			remaining_q    <= remaining_d;
			key_idx_q      <= key_idx_d;
			mask_key_q     <= mask_key_d;
			frame_opcode_q <= frame_opcode_d;
			frame_fin_q    <= frame_fin_d;
			frame_masked_q <= frame_masked_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= accept && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_s1      <= res;
			out_kind_s1 <= res_kind;
			out_last_s1 <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, out_s1};
	assign m_tuser  = out_kind_s1;
	assign m_tlast  = out_last_s1;

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remaining_q != '0)
		else $error("payload phase with nothing left");

	a_mask_phase_masked: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MASK |-> frame_masked_q)
		else $error("mask key read for an unmasked frame");

	a_last_returns_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_PAYLOAD && remaining_q == {{(LEN_W-1){1'b0}}, 1'b1}
		|=> phase_q == PH_HDR0)
		else $error("last payload byte did not end the frame");

	a_header_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && out_kind_s1 == KIND_HEADER |-> out_s1.payload_byte == '0)
		else $error("header summary carries a payload byte");

	a_empty_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && out_kind_s1 == KIND_HEADER && out_s1.payload_length == '0
		|-> out_last_s1)
		else $error("empty frame summary not marked last");

endmodule

`default_nettype wire
